// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the alarm panel RTL.
// Depends on nothing; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APC_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define APC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define APC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define APC_ASSERT(label, clk, rst, expr)
`define APC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define APC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/apc_pkg.sv =====
// Types and codes of the alarm panel controller.
// Used by the register block, the core and the top level.
`timescale 1ns / 1ps

package apc_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_ARMING = 3'd1,
    MODE_ARMED  = 3'd2,
    MODE_ENTRY  = 3'd3,
    MODE_ALARM  = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_ARMING       = 4'd1,
    EV_ARM_CANCEL   = 4'd2,
    EV_ARMED        = 4'd3,
    EV_DISARMED     = 4'd4,
    EV_ENTRY        = 4'd5,
    EV_ENTRY_STOP   = 4'd6,
    EV_ALARM        = 4'd7,
    EV_ALARM_END    = 4'd8,
    EV_ALARM_DISARM = 4'd9,
    EV_RETRIGGER    = 4'd10
  } event_t;

  typedef enum logic [2:0] {
    REG_ARM_DELAY      = 3'd0,
    REG_ENTRY_DELAY    = 3'd1,
    REG_ALARM_DURATION = 3'd2,
    REG_FLASH_ENABLE   = 3'd3,
    REG_SIREN_ENABLE   = 3'd4,
    REG_LIGHT_EN       = 3'd5,
    REG_NOTIFY_MASK    = 3'd6,
    REG_ARMED_AT_RESET = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] arm_delay;
    logic [15:0] entry_delay;
    logic [15:0] alarm_duration;
    logic        flash_enable;
    logic        siren_enable;
    logic        light_en;
    logic [1:0]  notify_mask;
    logic        armed_at_reset;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  alarm_count;
    logic [15:0] seconds_left;
    logic        flash_on;
    logic        siren_on;
    logic        light_on;
    logic [1:0]  alarm_message;
    logic [1:0]  disarm_message;
    logic        save_armed;
    event_t      event_res;
  } res_t;

endpackage

// ===== rtl/apc_tick_if.sv =====
// Input channel of the alarm panel controller: one beat per one-second tick.
// Depends on nothing.
`timescale 1ns / 1ps

interface apc_tick_if;
  logic valid;
  logic ready;
  logic tag_read;
  logic tag_known;

  modport source (output valid, output tag_read, output tag_known, input ready);
  modport sink (input valid, input tag_read, input tag_known, output ready);
endinterface

// ===== rtl/apc_result_if.sv =====
// Result channel of the alarm panel controller: one beat per tick.
// Depends on nothing.
`timescale 1ns / 1ps

interface apc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  alarm_count;
  logic [15:0] seconds_left;
  logic        flash_on;
  logic        siren_on;
  logic        light_on;
  logic [1:0]  alarm_message;
  logic [1:0]  disarm_message;
  logic        save_armed;
  logic [3:0]  event_res;

  modport source (
    output valid, output mode, output alarm_count, output seconds_left,
    output flash_on, output siren_on, output light_on, output alarm_message,
    output disarm_message, output save_armed, output event_res, input ready
  );
  modport sink (
    input valid, input mode, input alarm_count, input seconds_left,
    input flash_on, input siren_on, input light_on, input alarm_message,
    input disarm_message, input save_armed, input event_res, output ready
  );
endinterface

// ===== rtl/apc_cfg_regs.sv =====
// APB register block of the alarm panel controller.
// Depends on apc_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps

module apc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [apc_pkg::AddrWidth-1:0]    paddr,
  input  logic [apc_pkg::DataWidth-1:0]    pwdata,
  output logic [apc_pkg::DataWidth-1:0]    prdata,
  output logic                             pready,
  output apc_pkg::cfg_t                    cfg
);

  apc_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = apc_pkg::reg_idx_t'(paddr[apc_pkg::AddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        apc_pkg::REG_ARM_DELAY:      cfg.arm_delay      <= pwdata[15:0];
        apc_pkg::REG_ENTRY_DELAY:    cfg.entry_delay    <= pwdata[15:0];
        apc_pkg::REG_ALARM_DURATION: cfg.alarm_duration <= pwdata[15:0];
        apc_pkg::REG_FLASH_ENABLE:   cfg.flash_enable   <= pwdata[0];
        apc_pkg::REG_SIREN_ENABLE:   cfg.siren_enable   <= pwdata[0];
        apc_pkg::REG_LIGHT_EN:       cfg.light_en       <= pwdata[0];
        apc_pkg::REG_NOTIFY_MASK:    cfg.notify_mask    <= pwdata[1:0];
        apc_pkg::REG_ARMED_AT_RESET: cfg.armed_at_reset <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      apc_pkg::REG_ARM_DELAY:      prdata[15:0] = cfg.arm_delay;
      apc_pkg::REG_ENTRY_DELAY:    prdata[15:0] = cfg.entry_delay;
      apc_pkg::REG_ALARM_DURATION: prdata[15:0] = cfg.alarm_duration;
      apc_pkg::REG_FLASH_ENABLE:   prdata[0]    = cfg.flash_enable;
      apc_pkg::REG_SIREN_ENABLE:   prdata[0]    = cfg.siren_enable;
      apc_pkg::REG_LIGHT_EN:       prdata[0]    = cfg.light_en;
      apc_pkg::REG_NOTIFY_MASK:    prdata[1:0]  = cfg.notify_mask;
      apc_pkg::REG_ARMED_AT_RESET: prdata[0]    = cfg.armed_at_reset;
      default:                     prdata       = '0;
    endcase
  end

endmodule

// ===== rtl/apc_core.sv =====
// Mode state machine, countdown and alarm counter with the result register.
// Depends on apc_pkg, the two channel interfaces and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module apc_core (
  input  logic          clk,
  input  logic          rst,
  input  apc_pkg::cfg_t cfg,
  apc_tick_if.sink      tick,
  apc_result_if.source  result
);

  apc_pkg::mode_t  mode_reg;
  logic [7:0]      alarm_counter;
  logic [15:0]     countdown_reg;
  logic            pending_good;
  logic            pending_bad;
  logic [2:0]      drive_bits;
  logic            restore_due;

  apc_pkg::res_t   res;
  logic            res_valid;
  logic            accept;

  apc_pkg::mode_t  mode_cur;
  apc_pkg::mode_t  mode_next;
  logic [7:0]      alarm_counter_next;
  logic [7:0]      raised_count;
  logic [15:0]     countdown_load;
  logic [15:0]     countdown_next;
  logic            pending_good_next;
  logic            pending_bad_next;
  logic [2:0]      drive_bits_next;
  logic            good;
  logic            bad;
  logic            expired;
  apc_pkg::event_t event_code;
  logic [1:0]      alarm_msg;
  logic [1:0]      disarm_msg;
  logic            save;

  assign tick.ready = !res_valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  assign mode_cur     = restore_due ? (cfg.armed_at_reset ? apc_pkg::MODE_ARMED
                                                          : apc_pkg::MODE_IDLE)
                                    : mode_reg;
  assign good         = tick.tag_read ? tick.tag_known : pending_good;
  assign bad          = tick.tag_read ? !tick.tag_known : pending_bad;
  assign expired      = (countdown_reg == 16'd0);
  assign raised_count = (alarm_counter == 8'hFF) ? 8'hFF : alarm_counter + 8'd1;

  always_comb begin
    mode_next          = mode_cur;
    alarm_counter_next = alarm_counter;
    countdown_load     = countdown_reg;
    pending_good_next  = good;
    pending_bad_next   = bad;
    drive_bits_next    = drive_bits;
    event_code         = apc_pkg::EV_NONE;
    alarm_msg          = 2'b00;
    disarm_msg         = 2'b00;
    save               = 1'b0;
    unique case (mode_cur)
      apc_pkg::MODE_ARMING: begin
        if (good) begin
          pending_good_next = 1'b0;
          mode_next         = apc_pkg::MODE_IDLE;
          event_code        = apc_pkg::EV_ARM_CANCEL;
        end else if (expired) begin
          mode_next          = apc_pkg::MODE_ARMED;
          alarm_counter_next = 8'd0;
          save               = 1'b1;
          event_code         = apc_pkg::EV_ARMED;
        end
      end
      apc_pkg::MODE_ARMED: begin
        if (good) begin
          pending_good_next = 1'b0;
          mode_next         = apc_pkg::MODE_IDLE;
          save              = 1'b1;
          event_code        = apc_pkg::EV_DISARMED;
        end else if (bad) begin
          pending_bad_next = 1'b0;
          mode_next        = apc_pkg::MODE_ENTRY;
          countdown_load   = cfg.entry_delay;
          event_code       = apc_pkg::EV_ENTRY;
        end
      end
      apc_pkg::MODE_ENTRY: begin
        if (good) begin
          pending_good_next = 1'b0;
          mode_next         = apc_pkg::MODE_IDLE;
          event_code        = apc_pkg::EV_ENTRY_STOP;
        end else if (bad || expired) begin
          pending_bad_next   = 1'b0;
          mode_next          = apc_pkg::MODE_ALARM;
          alarm_counter_next = raised_count;
          countdown_load     = cfg.alarm_duration;
          alarm_msg          = cfg.notify_mask;
          drive_bits_next    = {cfg.light_en, cfg.siren_enable, cfg.flash_enable};
          event_code         = apc_pkg::EV_ALARM;
        end
      end
      apc_pkg::MODE_ALARM: begin
        if (good) begin
          pending_good_next  = 1'b0;
          mode_next          = apc_pkg::MODE_IDLE;
          alarm_counter_next = 8'd0;
          drive_bits_next    = 3'b000;
          disarm_msg         = cfg.notify_mask;
          event_code         = apc_pkg::EV_ALARM_DISARM;
        end else if (bad) begin
          pending_bad_next   = 1'b0;
          alarm_counter_next = raised_count;
          countdown_load     = cfg.alarm_duration;
          event_code         = apc_pkg::EV_RETRIGGER;
        end else if (expired) begin
          mode_next          = apc_pkg::MODE_ARMED;
          alarm_counter_next = 8'd0;
          drive_bits_next    = 3'b000;
          event_code         = apc_pkg::EV_ALARM_END;
        end
      end
      default: begin
        mode_next = apc_pkg::MODE_IDLE;
        if (good) begin
          pending_good_next = 1'b0;
          mode_next         = apc_pkg::MODE_ARMING;
          countdown_load    = cfg.arm_delay;
          event_code        = apc_pkg::EV_ARMING;
        end
      end
    endcase
    countdown_next = (countdown_load != 16'd0) ? countdown_load - 16'd1
                                               : countdown_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      restore_due   <= 1'b1;
      mode_reg      <= apc_pkg::MODE_IDLE;
      alarm_counter <= '0;
      countdown_reg <= '0;
      pending_good  <= 1'b0;
      pending_bad   <= 1'b0;
      drive_bits    <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        restore_due   <= 1'b0;
        mode_reg      <= mode_next;
        alarm_counter <= alarm_counter_next;
        countdown_reg <= countdown_next;
        pending_good  <= pending_good_next;
        pending_bad   <= pending_bad_next;
        drive_bits    <= drive_bits_next;
        res_valid     <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.mode           <= mode_next;
      res.alarm_count    <= alarm_counter_next;
      res.seconds_left   <= countdown_next;
      res.flash_on       <= drive_bits_next[0];
      res.siren_on       <= drive_bits_next[1];
      res.light_on       <= drive_bits_next[2];
      res.alarm_message  <= alarm_msg;
      res.disarm_message <= disarm_msg;
      res.save_armed     <= save;
      res.event_res      <= event_code;
    end
  end

  assign result.valid          = res_valid;
  assign result.mode           = res.mode;
  assign result.alarm_count    = res.alarm_count;
  assign result.seconds_left   = res.seconds_left;
  assign result.flash_on       = res.flash_on;
  assign result.siren_on       = res.siren_on;
  assign result.light_on       = res.light_on;
  assign result.alarm_message  = res.alarm_message;
  assign result.disarm_message = res.disarm_message;
  assign result.save_armed     = res.save_armed;
  assign result.event_res      = res.event_res;

  `APC_ASSERT(a_pending_exclusive, clk, rst, !(pending_good && pending_bad))
  `APC_ASSERT_IMPL(a_drives_only_in_alarm, clk, rst,
                   mode_reg != apc_pkg::MODE_ALARM, drive_bits == 3'b000)
  `APC_ASSERT_IMPL(a_save_on_arm_events, clk, rst, res_valid && res.save_armed,
                   res.event_res == apc_pkg::EV_ARMED || res.event_res == apc_pkg::EV_DISARMED)
  `APC_ASSERT_IMPL(a_alarm_msg_on_alarm, clk, rst, res_valid && res.alarm_message != 2'b00,
                   res.event_res == apc_pkg::EV_ALARM)
  `APC_ASSERT_NEXT(a_beat_gives_result, clk, rst, accept,
                   res_valid && res.mode == mode_reg)

endmodule

// ===== rtl/alarm_panel_controller.sv =====
// Alarm panel controller: one tick beat in, one result beat out, takes a beat every
// clock cycle. The mode update and countdown of a tick are combinational and the
// result sits in an output register from the next cycle; input ready drops only
// while that register holds a result the sink has not taken. After reset the
// armed_at_reset register selects armed or idle on the first tick. Registers sit at
// byte address 4*i in the order arm_delay, entry_delay, alarm_duration,
// flash_enable, siren_enable, light_en, notify_mask, armed_at_reset.
// Depends on apc_pkg, apc_tick_if, apc_result_if, apc_cfg_regs and apc_core.
`timescale 1ns / 1ps

module alarm_panel_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apc_pkg::AddrWidth-1:0] paddr,
  input  logic [apc_pkg::DataWidth-1:0] pwdata,
  output logic [apc_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  apc_tick_if.sink                      tick,
  apc_result_if.source                  result
);

  apc_pkg::cfg_t cfg;

  apc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  apc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .tick   (tick),
    .result (result)
  );

endmodule
